// File: hw/rtl/sftg_pkg.sv
// Shared types, widths and constants of the slice filter tap generator.
// Holds the 2^(-i/16) table and the divider request and response structs.
// No dependencies.
package sftg_pkg;

   localparam int POS_W      = 24;
   localparam int DIR_W      = 16;
   localparam int WT_W       = 17;
   localparam int OFS_W      = 6;
   localparam int MODE_W     = 2;
   localparam int FWHM_W     = 12;
   localparam int AXES       = 3;
   localparam int MAX_TAPS   = 64;
   localparam int ADDR_W     = $clog2(MAX_TAPS);
   localparam int RAW_W      = 32;
   localparam int SUM_W      = 40;
   localparam int SAMPLES    = 9;
   localparam int SAMP_W     = $clog2(SAMPLES + 1);
   localparam int LIM_W      = ADDR_W - 1;
   localparam int CW         = 24;
   localparam int XW         = CW + 2;
   localparam int HW_W       = 22;
   localparam int SIGMA_W    = 20;
   localparam int SIG2_W     = 2 * SIGMA_W;
   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 40;
   localparam int DIV_STEPS  = 21;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int ESUM_W     = 20;
   localparam int V_W        = 22;
   localparam int K_W        = 6;
   localparam int PACC_W     = 30;
   localparam int CSR_DATA_W = FWHM_W;

   localparam int Q_ONE      = 65536;
   localparam int Q_HALF     = 32768;
   localparam int SIGMA_K    = 39358;
   localparam int LOG2E_Q16  = 94548;
   localparam int EXP_K_MAX  = 30;
   localparam int POS_MAX    = 8388607;
   localparam int POS_MIN    = -8388608;
   localparam int FWHM_RESET = 256;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEAREST,
      MODE_BOX,
      MODE_TRI,
      MODE_GAUSS
   } mode_type;

   typedef enum logic [0:0] {
      CSR_MODE,
      CSR_FWHM
   } csr_idx_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_STEPS-1:0] quo;
   } div_rsp_type;

   function automatic logic [16:0] pow2_frac(input logic [4:0] idx);
      logic [16:0] r;
      unique case (idx)
         5'd0:    r = 17'd65536;
         5'd1:    r = 17'd62757;
         5'd2:    r = 17'd60097;
         5'd3:    r = 17'd57549;
         5'd4:    r = 17'd55109;
         5'd5:    r = 17'd52773;
         5'd6:    r = 17'd50535;
         5'd7:    r = 17'd48393;
         5'd8:    r = 17'd46341;
         5'd9:    r = 17'd44376;
         5'd10:   r = 17'd42495;
         5'd11:   r = 17'd40693;
         5'd12:   r = 17'd38968;
         5'd13:   r = 17'd37316;
         5'd14:   r = 17'd35734;
         5'd15:   r = 17'd34219;
         default: r = 17'd32768;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/sftg_if.sv
// Channel interfaces of the slice filter tap generator: request, response, csr.
// Depends on sftg_pkg.
interface sftg_req_if import sftg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;
   modport source(output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface sftg_rsp_if import sftg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [WT_W-1:0]         tap_weight;
   logic signed [OFS_W-1:0] tap_offset;
   logic signed [POS_W-1:0] out_x;
   logic signed [POS_W-1:0] out_y;
   logic signed [POS_W-1:0] out_z;
   logic                    last_tap;
   modport source(output valid, tap_weight, tap_offset, out_x, out_y, out_z, last_tap,
                  input ready);
   modport sink(input valid, tap_weight, tap_offset, out_x, out_y, out_z, last_tap,
                output ready);
endinterface

interface sftg_csr_if import sftg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_idx_type           index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/sftg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sftg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sftg_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on sftg_pkg.
module sftg_mul import sftg_pkg::*; (
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/sftg_div.sv
// Shared restoring divider, one quotient bit per cycle, DIV_STEPS bits.
// The numerator shifted right by DIV_STEPS must be below the denominator.
// Depends on sftg_pkg.
module sftg_div import sftg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_STEPS-1:0] shq_ff, shq_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   assign trial = {rem_ff, shq_ff[DIV_STEPS-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shq_in  = shq_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = req.num[DIV_STEPS +: DIV_DEN_W];
         shq_in  = req.num[DIV_STEPS-1:0];
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         shq_in = {shq_ff[DIV_STEPS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      shq_ff <= shq_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = shq_ff;

endmodule

// File: hw/rtl/slice_filter_tap_generator.sv
// Slice filter tap generator: top level with the tap sequencer.
// Depends on sftg_pkg, sftg_if, sftg_ram, sftg_mul and sftg_div.
//
// Usage: write filter_mode (index 0) and fwhm (index 1, Q4.8) on csr_bus while
// idle; csr_bus.ready is always high. Each beat on req_bus (position Q15.8,
// direction Q3.12) yields 2L+1 beats on rsp_bus, one per tap t = -L..L, the
// last one flagged by last_tap; nearest mode yields a single tap.
// req_bus.ready is high only while no item is in flight; one item at a time.
// Raw weights are built tap by tap through one shared multiplier and one shared
// 21-step divider, then normalized on the way out. Per item, after the beat,
// setup runs; then each tap's raw weight is built (box directly, triangle with
// one division per side of zero that the tap covers, gaussian as nine samples
// with one division each) and written to the RAM; then the position
// accumulators are seeded; then each output tap takes a RAM read and one
// division, plus any stall. The widest gaussian yields 59 taps.
// Nearest mode skips setup and the kernel and yields one tap.
// A stalled rsp_bus holds the current beat and freezes the sequencer.
// Reset returns to idle and sets filter_mode to nearest and fwhm to 1.0.
module slice_filter_tap_generator import sftg_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sftg_req_if.sink   req_bus,
   sftg_rsp_if.source rsp_bus,
   sftg_csr_if.sink   csr_bus
);

   typedef enum logic [4:0] {
      S_IDLE, S_SET0, S_SET1, S_SET2, S_SET3, S_TAP, S_KERN,
      S_TL0, S_TL1, S_TL2, S_TR0, S_TR1, S_TR2,
      S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_G9, S_G10, S_G11,
      S_WR, S_PREP, S_RD, S_RD1, S_RD2, S_OUT
   } state_type;

   localparam logic signed [CW-1:0]     HALF_S = CW'(Q_HALF);
   localparam logic signed [PACC_W-1:0] PMAX   = PACC_W'(POS_MAX);
   localparam logic signed [PACC_W-1:0] PMIN   = PACC_W'(POS_MIN);
   localparam int                       SAMP_RECIP    = 1864136;
   localparam int                       SAMP_RECIP_SH = 25;

   function automatic logic [MUL_W-1:0] clip0(input logic signed [XW-1:0] v);
      return v[XW-1] ? '0 : v[MUL_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic [FWHM_W-1:0]       fwhm_ff, fwhm_in;
   mode_type                cur_ff, cur_in;
   logic signed [DIR_W-1:0] dir_ff [AXES];
   logic signed [DIR_W-1:0] dir_in [AXES];
   logic signed [PACC_W-1:0] acc_ff [AXES];
   logic signed [PACC_W-1:0] acc_in [AXES];
   logic [SIGMA_W-1:0]      sigma_ff, sigma_in;
   logic [SIG2_W-1:0]       sig2_ff, sig2_in;
   logic [HW_W-1:0]         hw_ff, hw_in;
   logic [LIM_W-1:0]        lim_ff, lim_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic signed [CW-1:0]    a_ff, a_in, b_ff, b_in;
   logic [MUL_W-1:0]        dw_ff, dw_in;
   logic [MUL_W-1:0]        ax_ff, ax_in;
   logic [SAMP_W-1:0]       samp_ff, samp_in;
   logic [ESUM_W-1:0]       esum_ff, esum_in;
   logic [DIV_STEPS-1:0]    u_ff, u_in;
   logic [V_W-1:0]          v_ff, v_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [16:0]             t0_ff, t0_in;
   logic [RAW_W-1:0]        w_ff, w_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WT_W-1:0]         wt_ff, wt_in;
   logic signed [OFS_W-1:0] ofs_ff, ofs_in;
   logic signed [POS_W-1:0] opos_ff [AXES];
   logic signed [POS_W-1:0] opos_in [AXES];
   logic                    last_ff, last_in;

   logic signed [POS_W-1:0] req_pos [AXES];
   logic signed [DIR_W-1:0] req_dir [AXES];
   logic signed [POS_W-1:0] pos_sat [AXES];
   logic                    req_take;
   logic signed [6:0]       t7;
   logic [ADDR_W-1:0]       last_idx;
   logic signed [CW-1:0]    tap_q, hw_s, tap_a, tap_b;
   logic signed [XW-1:0]    a_x, b_x, e_x, s_x, hw2_x, x_x;
   logic [MUL_W-1:0]        g_off;
   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [PROD_W-1:0]       mul_p;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    ram_we;
   logic [RAW_W-1:0]        ram_rd;
   logic [3:0]              tix;
   logic [16:0]             t1, val;
   logic [31:0]             expv;
   logic [ADDR_W-1:0]       ntaps;

   assign req_pos[0] = req_bus.pos_x;
   assign req_pos[1] = req_bus.pos_y;
   assign req_pos[2] = req_bus.pos_z;
   assign req_dir[0] = req_bus.dir_x;
   assign req_dir[1] = req_bus.dir_y;
   assign req_dir[2] = req_bus.dir_z;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign t7       = $signed({1'b0, idx_ff}) - $signed({2'b00, lim_ff});
   assign last_idx = {lim_ff, 1'b0};
   assign ntaps    = {lim_ff, 1'b1};
   assign tap_q    = {{(CW-23){t7[6]}}, t7, 16'd0};
   assign hw_s     = $signed({{(CW-HW_W){1'b0}}, hw_ff});
   assign tap_a    = (idx_ff == '0) ? -hw_s : tap_q - HALF_S;
   assign tap_b    = (idx_ff == last_idx) ? hw_s : tap_q + HALF_S;

   assign a_x   = {{2{a_ff[CW-1]}}, a_ff};
   assign b_x   = {{2{b_ff[CW-1]}}, b_ff};
   assign e_x   = b_ff[CW-1] ? b_x : '0;
   assign s_x   = (a_x > 0) ? a_x : '0;
   assign hw2_x = $signed({{(XW-HW_W-1){1'b0}}, hw_ff, 1'b0});
   assign g_off = MUL_W'(mul_p >> SAMP_RECIP_SH);
   assign x_x   = a_x + $signed({{(XW-MUL_W){1'b0}}, g_off});

   assign tix  = v_ff[15:12];
   assign t1   = pow2_frac({1'b0, tix} + 5'd1);
   assign val  = t0_ff - 17'((mul_p + PROD_W'(2048)) >> 12);
   assign expv = (k_ff > K_W'(EXP_K_MAX)) ? '0 :
                 ((32'(val) + ((32'd1 << k_ff) >> 1)) >> k_ff);

   always_comb begin
      for (int c = 0; c < AXES; c++) begin
         logic signed [PACC_W-1:0] pr;
         pr = (acc_ff[c] + PACC_W'(8)) >>> 4;
         if (pr > PMAX) begin
            pos_sat[c] = POS_W'(POS_MAX);
         end else if (pr < PMIN) begin
            pos_sat[c] = POS_W'(POS_MIN);
         end else begin
            pos_sat[c] = pr[POS_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      fwhm_in      = fwhm_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      acc_in       = acc_ff;
      sigma_in     = sigma_ff;
      sig2_in      = sig2_ff;
      hw_in        = hw_ff;
      lim_in       = lim_ff;
      idx_in       = idx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      dw_in        = dw_ff;
      ax_in        = ax_ff;
      samp_in      = samp_ff;
      esum_in      = esum_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      t0_in        = t0_ff;
      w_in         = w_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      wt_in        = wt_ff;
      ofs_in       = ofs_ff;
      opos_in      = opos_ff;
      last_in      = last_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      ram_we       = 1'b0;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MODE: mode_in = mode_type'(csr_bus.data[MODE_W-1:0]);
            CSR_FWHM: fwhm_in = csr_bus.data;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cur_in = mode_ff;
               sum_in = '0;
               idx_in = '0;
               for (int c = 0; c < AXES; c++) begin
                  dir_in[c] = req_dir[c];
                  acc_in[c] = {{(PACC_W-POS_W-4){req_pos[c][POS_W-1]}}, req_pos[c], 4'd0};
               end
               if (mode_ff == MODE_NEAREST) begin
                  lim_in   = '0;
                  w_in     = RAW_W'(Q_ONE);
                  state_in = S_WR;
               end else begin
                  state_in = S_SET0;
               end
            end
         end
         S_SET0: begin
            mul_a    = MUL_W'(fwhm_ff);
            mul_b    = MUL_W'(SIGMA_K);
            state_in = S_SET1;
         end
         S_SET1: begin
            sigma_in = SIGMA_W'((mul_p + PROD_W'(128)) >> 8);
            state_in = S_SET2;
         end
         S_SET2: begin
            mul_a = MUL_W'(sigma_ff);
            mul_b = MUL_W'(sigma_ff);
            priority case (cur_ff)
               MODE_BOX: hw_in = HW_W'({fwhm_ff, 7'd0});
               MODE_TRI: hw_in = HW_W'({fwhm_ff, 8'd0});
               default:  hw_in = HW_W'({sigma_ff, 1'b0}) + HW_W'(sigma_ff);
            endcase
            state_in = S_SET3;
         end
         S_SET3: begin
            logic [HW_W-1:0] hr;
            hr       = hw_ff + HW_W'(Q_HALF);
            sig2_in  = mul_p[SIG2_W-1:0];
            lim_in   = (hr[HW_W-1:16] > (HW_W-16)'((MAX_TAPS - 1) / 2)) ?
                       LIM_W'((MAX_TAPS - 1) / 2) : LIM_W'(hr[HW_W-1:16]);
            state_in = S_TAP;
         end
         S_TAP: begin
            a_in     = tap_a;
            b_in     = tap_b;
            w_in     = '0;
            state_in = S_KERN;
         end
         S_KERN: begin
            priority case (cur_ff)
               MODE_BOX: begin
                  w_in     = RAW_W'(clip0(b_x - a_x));
                  state_in = S_WR;
               end
               MODE_TRI: begin
                  state_in = (hw_ff == '0) ? S_WR : S_TL0;
               end
               default: begin
                  dw_in    = clip0(b_x - a_x);
                  samp_in  = '0;
                  esum_in  = '0;
                  state_in = (b_x > a_x && sigma_ff != '0) ? S_G0 : S_WR;
               end
            endcase
         end
         S_TL0: begin
            mul_a    = clip0(e_x - a_x);
            mul_b    = clip0(a_x + e_x + hw2_x);
            state_in = a_ff[CW-1] ? S_TL1 : S_TR0;
         end
         S_TL1: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(mul_p) + DIV_NUM_W'(hw_ff);
            div_req.den   = DIV_DEN_W'({hw_ff, 1'b0});
            state_in      = S_TL2;
         end
         S_TL2: begin
            if (div_rsp.done) begin
               w_in     = w_ff + RAW_W'(div_rsp.quo);
               state_in = S_TR0;
            end
         end
         S_TR0: begin
            mul_a    = clip0(b_x - s_x);
            mul_b    = clip0(hw2_x - s_x - b_x);
            state_in = (b_x > 0) ? S_TR1 : S_WR;
         end
         S_TR1: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(mul_p) + DIV_NUM_W'(hw_ff);
            div_req.den   = DIV_DEN_W'({hw_ff, 1'b0});
            state_in      = S_TR2;
         end
         S_TR2: begin
            if (div_rsp.done) begin
               w_in     = w_ff + RAW_W'(div_rsp.quo);
               state_in = S_WR;
            end
         end
         S_G0: begin
            mul_a    = dw_ff;
            mul_b    = MUL_W'({samp_ff, 1'b1});
            state_in = S_G1;
         end
         S_G1: begin
            mul_a    = MUL_W'(mul_p + PROD_W'(SAMPLES));
            mul_b    = MUL_W'(SAMP_RECIP);
            state_in = S_G2;
         end
         S_G2: begin
            ax_in    = x_x[XW-1] ? clip0(-x_x) : clip0(x_x);
            state_in = S_G3;
         end
         S_G3: begin
            mul_a    = ax_ff;
            mul_b    = ax_ff;
            state_in = S_G4;
         end
         S_G4: begin
            div_req.start = 1'b1;
            div_req.num   = {DIV_NUM_W'(mul_p) << 16} + DIV_NUM_W'(sig2_ff >> 1);
            div_req.den   = DIV_DEN_W'(sig2_ff);
            state_in      = S_G5;
         end
         S_G5: begin
            if (div_rsp.done) begin
               u_in     = div_rsp.quo;
               state_in = S_G6;
            end
         end
         S_G6: begin
            mul_a    = MUL_W'(u_ff);
            mul_b    = MUL_W'(LOG2E_Q16);
            state_in = S_G7;
         end
         S_G7: begin
            v_in     = V_W'((mul_p + PROD_W'(Q_HALF)) >> 16);
            state_in = S_G8;
         end
         S_G8: begin
            t0_in    = pow2_frac({1'b0, tix});
            k_in     = K_W'(v_ff[V_W-1:16]);
            mul_a    = MUL_W'(pow2_frac({1'b0, tix}) - t1);
            mul_b    = MUL_W'(v_ff[11:0]);
            state_in = S_G9;
         end
         S_G9: begin
            esum_in = esum_ff + ESUM_W'(expv);
            samp_in = samp_ff + 1'b1;
            state_in = (samp_ff == SAMP_W'(SAMPLES - 1)) ? S_G10 : S_G0;
         end
         S_G10: begin
            mul_a    = dw_ff;
            mul_b    = MUL_W'(esum_ff);
            state_in = S_G11;
         end
         S_G11: begin
            w_in     = RAW_W'((mul_p + PROD_W'(Q_HALF)) >> 16);
            state_in = S_WR;
         end
         S_WR: begin
            ram_we = 1'b1;
            sum_in = sum_ff + SUM_W'(w_ff);
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               state_in = S_PREP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TAP;
            end
         end
         S_PREP: begin
            if (idx_ff == ADDR_W'(lim_ff)) begin
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               for (int c = 0; c < AXES; c++) begin
                  acc_in[c] = acc_ff[c] - PACC_W'(dir_ff[c]);
               end
            end
         end
         S_RD: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            div_req.start = 1'b1;
            if (sum_ff == '0) begin
               div_req.num = DIV_NUM_W'(Q_ONE) + DIV_NUM_W'(ntaps >> 1);
               div_req.den = DIV_DEN_W'(ntaps);
            end else begin
               div_req.num = DIV_NUM_W'({ram_rd, 16'd0}) + DIV_NUM_W'(sum_ff >> 1);
               div_req.den = DIV_DEN_W'(sum_ff);
            end
            state_in = S_RD2;
         end
         S_RD2: begin
            if (div_rsp.done) begin
               wt_in        = (div_rsp.quo > DIV_STEPS'(Q_ONE)) ?
                              WT_W'(Q_ONE) : WT_W'(div_rsp.quo);
               ofs_in       = t7[OFS_W-1:0];
               opos_in      = pos_sat;
               last_in      = (idx_ff == last_idx);
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               for (int c = 0; c < AXES; c++) begin
                  acc_in[c] = acc_ff[c] + PACC_W'(dir_ff[c]);
               end
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_NEAREST;
         fwhm_ff      <= FWHM_W'(FWHM_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         fwhm_ff      <= fwhm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      dir_ff   <= dir_in;
      acc_ff   <= acc_in;
      sigma_ff <= sigma_in;
      sig2_ff  <= sig2_in;
      hw_ff    <= hw_in;
      lim_ff   <= lim_in;
      idx_ff   <= idx_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      dw_ff    <= dw_in;
      ax_ff    <= ax_in;
      samp_ff  <= samp_in;
      esum_ff  <= esum_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      k_ff     <= k_in;
      t0_ff    <= t0_in;
      w_ff     <= w_in;
      sum_ff   <= sum_in;
      wt_ff    <= wt_in;
      ofs_ff   <= ofs_in;
      opos_ff  <= opos_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.tap_weight = wt_ff;
   assign rsp_bus.tap_offset = ofs_ff;
   assign rsp_bus.out_x      = opos_ff[0];
   assign rsp_bus.out_y      = opos_ff[1];
   assign rsp_bus.out_z      = opos_ff[2];
   assign rsp_bus.last_tap   = last_ff;

   sftg_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   sftg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sftg_ram #(
      .WIDTH (RAW_W),
      .DEPTH (MAX_TAPS)
   ) u_raw_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (w_ff),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

endmodule

// File: test/tb_slice_filter_tap_generator.sv
// Self-checking testbench of slice_filter_tap_generator: drives position and direction
// beats, predicts every tap beat in all four filter modes and compares them field by field.
// Depends on sftg_pkg, sftg_if and the RTL of the block.
module tb_slice_filter_tap_generator;
   import sftg_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int NUM_SETTINGS = 14;

   typedef struct {
      logic signed [POS_W-1:0] px, py, pz;
      logic signed [DIR_W-1:0] dx, dy, dz;
   } sample_type;

   typedef struct {
      logic [WT_W-1:0]         weight;
      logic signed [OFS_W-1:0] offset;
      logic signed [POS_W-1:0] x, y, z;
      logic                    last;
   } tap_beat_type;

   logic clock = 0;
   logic reset = 1;

   sftg_req_if req_bus ();
   sftg_rsp_if rsp_bus ();
   sftg_csr_if csr_bus ();

   slice_filter_tap_generator uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   sample_type   pending_samples[$];
   tap_beat_type expected_taps[$];
   mode_type  cfg_mode = MODE_NEAREST;
   int unsigned cfg_fwhm = FWHM_RESET;
   int tx_idle = 28;
   int rx_idle = 82;
   logic hold_rx = 0;
   int errors = 0;
   int samples_sent = 0;
   int taps_seen = 0;
   longint cycles = 0;

   longint unsigned pow2_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
      46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   always #6 clock = ~clock;

   function automatic longint unsigned clamp0(input longint v);
      return (v < 0) ? 0 : longint'(v);
   endfunction

   function automatic longint unsigned exp_neg(input longint unsigned u);
      longint unsigned v, k, f, idx, fr, t0, t1, val;
      v = (u * LOG2E_Q16 + 32768) >> 16;
      k = v >> 16;
      if (k > EXP_K_MAX) return 0;
      f = v & 16'hFFFF;
      idx = f >> 12;
      fr = f & 12'hFFF;
      t0 = pow2_tab[idx];
      t1 = pow2_tab[idx + 1];
      val = t0 - ((((t0 - t1) * fr) + 2048) >> 12);
      return (val + ((64'd1 << k) >> 1)) >> k;
   endfunction

   function automatic logic [POS_W-1:0] tap_pos(input longint p, input longint d,
                                                 input longint t);
      longint r;
      r = (p * 16 + t * d + 8) >>> 4;
      if (r > POS_MAX) r = POS_MAX;
      if (r < POS_MIN) r = POS_MIN;
      return r[POS_W-1:0];
   endfunction

   task automatic predict_taps(input sample_type smp);
      longint hw, sigma, lim, t, a, b, e, s, n, x;
      longint unsigned w, sum, dw, sig2, esum, ax, u, wt, den, off;
      longint unsigned store[MAX_TAPS];
      tap_beat_type beat;
      hw = 0;
      sigma = 0;
      lim = 0;
      sum = 0;
      if (cfg_mode == MODE_NEAREST) begin
         store[0] = Q_ONE;
         sum = Q_ONE;
      end else begin
         if (cfg_mode == MODE_BOX) hw = longint'(cfg_fwhm) * 128;
         else if (cfg_mode == MODE_TRI) hw = longint'(cfg_fwhm) * 256;
         else begin
            sigma = (longint'(cfg_fwhm) * SIGMA_K + 128) >>> 8;
            hw = 3 * sigma;
         end
         lim = (hw + Q_HALF) >>> 16;
         if (lim > (MAX_TAPS - 1) / 2) lim = (MAX_TAPS - 1) / 2;
         for (t = -lim; t <= lim; t++) begin
            a = (t == -lim) ? -hw : t * Q_ONE - Q_HALF;
            b = (t == lim) ? hw : t * Q_ONE + Q_HALF;
            w = 0;
            if (cfg_mode == MODE_BOX) begin
               w = clamp0(b - a);
            end else if (cfg_mode == MODE_TRI) begin
               if (hw > 0) begin
                  den = 2 * hw;
                  if (a < 0) begin
                     e = (b < 0) ? b : 0;
                     w += (clamp0(e - a) * clamp0(a + e + 2 * hw) + longint'(hw)) / den;
                  end
                  if (b > 0) begin
                     s = (a > 0) ? a : 0;
                     w += (clamp0(b - s) * clamp0(2 * hw - s - b) + longint'(hw)) / den;
                  end
               end
            end else if (b > a && sigma > 0) begin
               dw = b - a;
               sig2 = sigma * sigma;
               esum = 0;
               for (int k = 0; k < SAMPLES; k++) begin
                  off = (dw * (2 * k + 1) + SAMPLES) / (2 * SAMPLES);
                  x = a + longint'(off);
                  ax = (x < 0) ? -x : x;
                  u = (ax * ax * Q_ONE + sig2 / 2) / sig2;
                  esum += exp_neg(u);
               end
               w = (dw * esum + Q_HALF) >> 16;
            end
            store[t + lim] = (w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : w;
            sum += store[t + lim];
         end
      end
      sum &= 64'hFF_FFFF_FFFF;
      n = 2 * lim + 1;
      for (longint i = 0; i < n; i++) begin
         t = i - lim;
         if (sum == 0) wt = (Q_ONE + n / 2) / n;
         else wt = (store[i] * Q_ONE + sum / 2) / sum;
         if (wt > Q_ONE) wt = Q_ONE;
         beat.weight = wt[WT_W-1:0];
         beat.offset = t[OFS_W-1:0];
         beat.x = tap_pos(smp.px, smp.dx, t);
         beat.y = tap_pos(smp.py, smp.dy, t);
         beat.z = tap_pos(smp.pz, smp.dz, t);
         beat.last = (i == n - 1);
         expected_taps.push_back(beat);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("MISMATCH tap %0d %s: got %0d expected %0d", taps_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      sample_type smp;
      if (reset) begin
         req_bus.valid <= 0;
         req_bus.pos_x <= 0;
         req_bus.pos_y <= 0;
         req_bus.pos_z <= 0;
         req_bus.dir_x <= 0;
         req_bus.dir_y <= 0;
         req_bus.dir_z <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            smp.px = req_bus.pos_x;
            smp.py = req_bus.pos_y;
            smp.pz = req_bus.pos_z;
            smp.dx = req_bus.dir_x;
            smp.dy = req_bus.dir_y;
            smp.dz = req_bus.dir_z;
            predict_taps(smp);
            samples_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= tx_idle) begin
               smp = pending_samples.pop_front();
               req_bus.valid <= 1;
               req_bus.pos_x <= smp.px;
               req_bus.pos_y <= smp.py;
               req_bus.pos_z <= smp.pz;
               req_bus.dir_x <= smp.dx;
               req_bus.dir_y <= smp.dy;
               req_bus.dir_z <= smp.dz;
            end else begin
               req_bus.valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      tap_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            taps_seen++;
            if (expected_taps.size() == 0) begin
               report_mismatch("unexpected beat", rsp_bus.tap_offset, 0);
            end else begin
               want = expected_taps.pop_front();
               if (rsp_bus.tap_weight !== want.weight)
                  report_mismatch("tap_weight", rsp_bus.tap_weight, want.weight);
               if (rsp_bus.tap_offset !== want.offset)
                  report_mismatch("tap_offset", rsp_bus.tap_offset, want.offset);
               if (rsp_bus.out_x !== want.x) report_mismatch("out_x", rsp_bus.out_x, want.x);
               if (rsp_bus.out_y !== want.y) report_mismatch("out_y", rsp_bus.out_y, want.y);
               if (rsp_bus.out_z !== want.z) report_mismatch("out_z", rsp_bus.out_z, want.z);
               if (rsp_bus.last_tap !== want.last)
                  report_mismatch("last_tap", rsp_bus.last_tap, want.last);
            end
         end
         rsp_bus.ready <= !hold_rx && ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // hold the receiver off long enough for the block to stall its input
   initial begin
      wait (samples_sent == 40);
      @(posedge clock);
      hold_rx <= 1;
      repeat (400) @(posedge clock);
      hold_rx <= 0;
   end

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_bus.valid || expected_taps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      if (idx == CSR_MODE) cfg_mode = mode_type'(value[MODE_W-1:0]);
      else cfg_fwhm = value;
   endtask

   task automatic set_filter(input mode_type m, input int unsigned f);
      wait_drained();
      csr_write(CSR_MODE, CSR_DATA_W'(m));
      csr_write(CSR_FWHM, CSR_DATA_W'(f));
   endtask

   task automatic push_sample(input logic signed [POS_W-1:0] p,
                              input logic signed [DIR_W-1:0] d);
      sample_type smp;
      smp.px = p;
      smp.py = -p - 1;
      smp.pz = p ^ 24'h5A5A5A;
      smp.dx = d;
      smp.dy = -d - 1;
      smp.dz = d ^ 16'h3C3C;
      pending_samples.push_back(smp);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(7))
         0: return 32'h007F_FFFF;
         1: return 32'hFF80_0000;
         2: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_random(input int count);
      sample_type smp;
      logic [31:0] r;
      repeat (count) begin
         r = rand_field();
         smp.px = r[POS_W-1:0];
         r = rand_field();
         smp.py = r[POS_W-1:0];
         r = rand_field();
         smp.pz = r[POS_W-1:0];
         r = rand_field();
         smp.dx = (r[31] && $urandom_range(1)) ? 16'h8000 : r[15:0];
         r = rand_field();
         smp.dy = (r[31] && $urandom_range(1)) ? 16'h7FFF : r[15:0];
         r = $urandom;
         smp.dz = r[DIR_W-1:0];
         pending_samples.push_back(smp);
      end
   endtask

   initial begin
      mode_type m;
      int unsigned f;
      csr_bus.valid = 0;
      csr_bus.index = CSR_MODE;
      csr_bus.data = 0;
      req_bus.valid = 0;
      rsp_bus.ready = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // reset settings, then nearest, box, triangle and gaussian with extreme fields and widths
      push_sample(24'sd0, 16'sd0);
      push_sample(24'sh7FFFFF, 16'sh7FFF);
      set_filter(MODE_NEAREST, 12'd100);
      push_sample(24'sh800000, 16'sh8000);
      push_sample(24'sh7FFFFF, 16'sh8000);
      set_filter(MODE_BOX, 12'hFFF);
      push_sample(24'sh7FFFFF, 16'sh7FFF);
      push_sample(24'sh800000, 16'sh8000);
      push_sample(24'sh800000, 16'sh7FFF);
      set_filter(MODE_BOX, 12'd0);
      push_sample(24'sd300, 16'sd4096);
      set_filter(MODE_BOX, 12'd256);
      push_sample(24'sd300, -16'sd4096);
      set_filter(MODE_TRI, 12'hFFF);
      push_sample(24'sh7FFF00, 16'sh7FFF);
      push_sample(-24'sd5, 16'sh8000);
      set_filter(MODE_TRI, 12'd0);
      push_sample(24'sd1, 16'sd1);
      set_filter(MODE_TRI, 12'd130);
      push_sample(-24'sd1, -16'sd1);
      set_filter(MODE_GAUSS, 12'd0);
      push_sample(24'sd77, 16'sd33);
      set_filter(MODE_GAUSS, 12'd1);
      push_sample(24'sd77, 16'sd33);
      set_filter(MODE_GAUSS, 12'hFFF);
      push_sample(24'sh7FFFFF, 16'sh7FFF);
      push_sample(24'sh800000, 16'sh8000);
      set_filter(MODE_GAUSS, 12'd256);
      push_sample(24'sd1000, 16'sd2000);
      push_sample(-24'sd1000, -16'sd2000);

      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         wait_drained();
         if (ph == NUM_SETTINGS / 3) begin
            tx_idle = 82;
            rx_idle = 28;
         end else if (ph == 2 * NUM_SETTINGS / 3) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         m = mode_type'(ph % 4);
         case (m)
            MODE_GAUSS: f = $urandom_range(768);
            MODE_NEAREST: f = $urandom_range(4095);
            default: f = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(900);
         endcase
         set_filter(m, f);
         push_random(26);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d samples and %0d tap beats over nearest, box, triangle, gaussian",
               samples_sent, taps_seen);
      $display("with zero and full-scale widths, saturated positions and output back-pressure");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
